// File: hw/rtl/psieve_pkg.sv
// Shared types and constants of the prime sieve stream block.
package psieve_pkg;

  localparam int LIMIT_W         = 17;
  localparam int MAX_NUMBERS_DEF = 131072;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd500;
  localparam int FIRST_PRIME     = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_UPPER_LIMIT = 1'b0;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FILL = 6'b000010,
    S_PRD  = 6'b000100,
    S_PCHK = 6'b001000,
    S_MARK = 6'b010000,
    S_SCAN = 6'b100000
  } psieve_state_t;

  // One result beat.
  typedef struct packed {
    logic [LIMIT_W-1:0] prime_value;
    logic               is_last;
    logic               exhausted;
  } psieve_res_t;

endpackage

// File: hw/rtl/prime_sieve_stream.sv
// Top level of the prime sieve stream block: register port, sequencer and map RAM.
//
// A pull is accepted at a rising edge with start high and busy low; its single
// result beat appears on the out_ ports for exactly one cycle, marked by
// out_valid, and the receiver cannot stall it, so it must take every beat. A
// pull with in_restart set, or the first pull after reset, runs a full sieve up
// to upper_limit (saturated to MAX_NUMBERS - 1) and then returns the first prime.
// That run fills the bitmap entries 0 to L (L being the latched limit), checks
// each candidate p with p*p <= L, strikes the multiples of each prime from p*p
// upward (roughly L * ln ln L of them in total) and then scans. Every pull, the
// first one included, then scans the bitmap one entry per cycle from the prime
// it hands out to the next one; this scan, limited by the single read port of
// the bitmap RAM, sets the steady pull rate. A result beat can coincide with
// acceptance of the next pull. The bitmap holds no reset value and needs no
// clearing pass: a sieve run writes every entry up to its limit before reading
// any. A new upper_limit takes effect at the next restart. Once the largest
// prime is handed out (is_last set), further pulls return prime 0 with
// exhausted set.
module prime_sieve_stream import psieve_pkg::*; #(
  parameter int MAX_NUMBERS = MAX_NUMBERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pull channel.
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_restart,
  // Result channel.
  output logic                  out_valid,
  output logic [LIMIT_W-1:0]    out_prime_value,
  output logic                  out_is_last,
  output logic                  out_exhausted,
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(MAX_NUMBERS);

  logic [LIMIT_W-1:0] limit_r;
  logic               reg_sel;
  logic               map_we;
  logic [AW-1:0]      map_waddr;
  logic               map_wdata;
  logic [AW-1:0]      map_raddr;
  logic               map_rdata;
  psieve_res_t        res;

  // Only the upper limit register exists; it answers at every address with bit 2 clear (byte addresses 0 to 3).
  assign reg_sel = (paddr[2] == CFG_IDX_UPPER_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  psieve_engine #(
    .MAX_NUMBERS(MAX_NUMBERS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .restart   (in_restart),
    .busy      (busy),
    .cfg_limit (limit_r),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata),
    .res_valid (out_valid),
    .res       (res)
  );

  // One bit per number: set while it is still a prime candidate.
  psieve_ram #(
    .WIDTH(1),
    .DEPTH(MAX_NUMBERS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign out_prime_value = res.prime_value;
  assign out_is_last     = res.is_last;
  assign out_exhausted   = res.exhausted;

endmodule

// File: hw/rtl/psieve_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module psieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/psieve_engine.sv
// Sieve sequencer: fills the map, strikes multiples and scans for primes.
module psieve_engine import psieve_pkg::*; #(
  parameter int MAX_NUMBERS = MAX_NUMBERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           restart,
  output logic                           busy,
  input  logic [LIMIT_W-1:0]             cfg_limit,
  output logic                           map_we,
  output logic [$clog2(MAX_NUMBERS)-1:0] map_waddr,
  output logic                           map_wdata,
  output logic [$clog2(MAX_NUMBERS)-1:0] map_raddr,
  input  logic                           map_rdata,
  output logic                           res_valid,
  output psieve_res_t                    res
);

  localparam int AW = $clog2(MAX_NUMBERS);
  localparam int NW = AW + 1;
  localparam int CW = (NW > LIMIT_W) ? NW : LIMIT_W;

  psieve_state_t state_r, state_nxt;
  logic [NW-1:0] lim_r, lim_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] p_r, p_nxt;
  logic [NW-1:0] sq_r, sq_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [AW-1:0] chk_n_r, chk_n_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic          ready_r, ready_nxt;
  logic          init_r, init_nxt;
  logic          res_valid_r, res_valid_nxt;
  psieve_res_t   res_r, res_nxt;

  logic [CW-1:0] lim_ext;
  logic [NW-1:0] lim_sat;
  logic [NW-1:0] idx_sum;
  logic [NW-1:0] sq_step;
  logic          idx_over;
  logic          found;
  logic          scan_done;
  logic [AW-1:0] scan_val;

  // Limits beyond the map saturate to its last entry.
  assign lim_ext = CW'(cfg_limit);
  assign lim_sat = (lim_ext > CW'(MAX_NUMBERS - 1)) ? NW'(MAX_NUMBERS - 1) : NW'(lim_ext);

  // The shared adder: +1 while filling or scanning, +p while striking multiples.
  assign idx_sum  = idx_r + ((state_r == S_MARK) ? p_r : NW'(1));
  // (p+1)^2 = p^2 + 2p + 1.
  assign sq_step  = sq_r + (p_r << 1) + NW'(1);
  assign idx_over = (idx_r > lim_r);

  assign found     = chk_v_r && map_rdata;
  assign scan_done = found || idx_over;
  assign scan_val  = found ? chk_n_r : '0;

  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    chk_v_nxt     = 1'b0;
    chk_n_nxt     = chk_n_r;
    cursor_nxt    = cursor_r;
    ready_nxt     = ready_r;
    init_nxt      = init_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    map_we        = 1'b0;
    map_wdata     = 1'b0;
    map_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (restart || !ready_r) begin
            lim_nxt   = lim_sat;
            idx_nxt   = '0;
            state_nxt = S_FILL;
          end else if (cursor_r == '0) begin
            res_valid_nxt = 1'b1;
            res_nxt       = '{prime_value: '0, is_last: 1'b0, exhausted: 1'b1};
          end else begin
            idx_nxt   = NW'(cursor_r) + NW'(1);
            init_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_FILL: begin
        map_we    = 1'b1;
        map_wdata = (idx_r >= NW'(FIRST_PRIME));
        if (idx_r == lim_r) begin
          p_nxt     = NW'(FIRST_PRIME);
          sq_nxt    = NW'(FIRST_PRIME * FIRST_PRIME);
          state_nxt = S_PRD;
        end else begin
          idx_nxt = idx_sum;
        end
      end
      S_PRD: begin
        map_raddr = p_r[AW-1:0];
        if (sq_r > lim_r) begin
          ready_nxt = 1'b1;
          init_nxt  = 1'b1;
          idx_nxt   = NW'(FIRST_PRIME);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (map_rdata) begin
          idx_nxt   = sq_r;
          state_nxt = S_MARK;
        end else begin
          p_nxt     = p_r + NW'(1);
          sq_nxt    = sq_step;
          state_nxt = S_PRD;
        end
      end
      S_MARK: begin
        if (idx_over) begin
          p_nxt     = p_r + NW'(1);
          sq_nxt    = sq_step;
          state_nxt = S_PRD;
        end else begin
          map_we  = 1'b1;
          idx_nxt = idx_sum;
        end
      end
      S_SCAN: begin
        // One read issued per cycle, checked the cycle after.
        if (scan_done) begin
          cursor_nxt = scan_val;
          if (init_r) begin
            init_nxt = 1'b0;
            if (scan_val == '0) begin
              res_valid_nxt = 1'b1;
              res_nxt       = '{prime_value: '0, is_last: 1'b0, exhausted: 1'b1};
              state_nxt     = S_IDLE;
            end else begin
              idx_nxt = NW'(scan_val) + NW'(1);
            end
          end else begin
            res_valid_nxt = 1'b1;
            res_nxt       = '{prime_value: LIMIT_W'(cursor_r),
                              is_last: (scan_val == '0), exhausted: 1'b0};
            state_nxt     = S_IDLE;
          end
        end else begin
          chk_v_nxt = 1'b1;
          chk_n_nxt = idx_r[AW-1:0];
          idx_nxt   = idx_sum;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_v_r     <= 1'b0;
      cursor_r    <= '0;
      ready_r     <= 1'b0;
      init_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      cursor_r    <= cursor_nxt;
      ready_r     <= ready_nxt;
      init_r      <= init_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r   <= lim_nxt;
    idx_r   <= idx_nxt;
    p_r     <= p_nxt;
    sq_r    <= sq_nxt;
    chk_n_r <= chk_n_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign map_waddr = idx_r[AW-1:0];
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: hw/rtl/psieve_checker.sv
// Port-level checker for the prime sieve stream block, with its bind.
module psieve_checker import psieve_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [LIMIT_W-1:0] out_prime_value,
  input logic               out_is_last,
  input logic               out_exhausted
);

  // A stretch of work always ends with the result beat of its pull.
  a_work_ends_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("engine went idle without a result beat");

  // Every beat follows a cycle of work or an accepted pull.
  a_beat_has_pull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result beat without a pull");

  // An accepted pull either starts work or answers at once.
  a_pull_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted pull neither worked on nor answered");

  // Exhausted beats carry no prime; real beats carry at least two.
  a_beat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exhausted ? (out_prime_value == '0 && !out_is_last)
                                 : (out_prime_value >= LIMIT_W'(FIRST_PRIME))))
    else $error("result value inconsistent with its flags");

endmodule

bind prime_sieve_stream psieve_checker u_psieve_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_prime_value (out_prime_value),
  .out_is_last     (out_is_last),
  .out_exhausted   (out_exhausted)
);
